### rtl/bsm_pkg.sv
package bsm_pkg;

    localparam logic [2:0] OP_CPU_READ  = 3'd0;
    localparam logic [2:0] OP_CPU_WRITE = 3'd1;
    localparam logic [2:0] OP_PPU_READ  = 3'd2;
    localparam logic [2:0] OP_PPU_WRITE = 3'd3;
    localparam logic [2:0] OP_TICK      = 3'd4;

    localparam logic [2:0] TGT_NONE    = 3'd0;
    localparam logic [2:0] TGT_PRG_ROM = 3'd1;
    localparam logic [2:0] TGT_PRG_RAM = 3'd2;
    localparam logic [2:0] TGT_CHR_ROM = 3'd3;
    localparam logic [2:0] TGT_NT_RAM  = 3'd4;

    localparam logic [1:0] MIR_HORIZONTAL  = 2'd0;
    localparam logic [1:0] MIR_VERTICAL    = 2'd1;
    localparam logic [1:0] MIR_FOUR_SCREEN = 2'd2;

    localparam logic [1:0] CFG_PRG_ROM_BANKS = 2'd0;
    localparam logic [1:0] CFG_CHR_ROM_KIB   = 2'd1;
    localparam logic [1:0] CFG_FOUR_SCREEN   = 2'd2;

    localparam logic [1:0] REG_SELECT = 2'd0;
    localparam logic [1:0] REG_MIRROR = 2'd1;
    localparam logic [1:0] REG_LATCH  = 2'd2;
    localparam logic [1:0] REG_ENABLE = 2'd3;

    localparam int CFG_DATA_W = 9;

    localparam logic [6:0] PRG_ROM_BANKS_RESET = 7'd32;
    localparam logic [8:0] CHR_ROM_KIB_RESET   = 9'd128;
    localparam logic [7:0] CHR_DEF_PAIR_RESET  = 8'd126;
    localparam logic [7:0] CHR_DEF_LAST_RESET  = 8'd127;

    typedef struct packed {
        logic       sel_wr;
        logic       bank_wr;
        logic       mirror_wr;
        logic [7:0] data;
    } bsm_bank_cmd_t;

    typedef struct packed {
        logic       tick;
        logic       latch_wr;
        logic       reload_wr;
        logic       enable_wr;
        logic       enable_val;
        logic [7:0] data;
    } bsm_irq_cmd_t;

endpackage

### rtl/bsm_bank.sv
module bsm_bank
    import bsm_pkg::*;
#(
    parameter int PRG_BANK_BITS = 6
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  bsm_bank_cmd_t            cmd,
    input  logic [1:0]               prg_sel,
    input  logic [2:0]               chr_sel,
    output logic [PRG_BANK_BITS-1:0] prg_bank,
    output logic [7:0]               chr_bank,
    output logic [1:0]               mirror_next
);

    localparam logic [PRG_BANK_BITS-1:0] PRG_SECOND_RESET =
        PRG_BANK_BITS'(PRG_ROM_BANKS_RESET - 7'd2);
    localparam logic [PRG_BANK_BITS-1:0] PRG_LAST_RESET =
        PRG_BANK_BITS'(PRG_ROM_BANKS_RESET - 7'd1);

    logic [6:0]               prg_rom_banks_reg, prg_rom_banks_next;
    logic [8:0]               chr_rom_kib_reg, chr_rom_kib_next;
    logic                     four_screen_reg, four_screen_next;
    logic [2:0]               select_index_reg, select_index_next;
    logic                     prg_swap_reg, prg_swap_next;
    logic                     chr_invert_reg, chr_invert_next;
    logic                     loaded_reg, loaded_next;
    logic [1:0]               mirroring_reg;
    logic [7:0]               bank_values_reg [8];
    logic [7:0]               bank_values_next [8];
    logic [PRG_BANK_BITS-1:0] prg_win_reg [4];
    logic [PRG_BANK_BITS-1:0] prg_win_next [4];
    logic [7:0]               chr_win_reg [8];
    logic [7:0]               chr_win_next [8];

    logic                     cfg_hit;
    logic [7:0]               prg_second8;
    logic [7:0]               prg_last8;
    logic [8:0]               chr_pair9;
    logic [8:0]               chr_last9;
    logic [PRG_BANK_BITS-1:0] prg_second;
    logic [PRG_BANK_BITS-1:0] prg_last;
    logic [PRG_BANK_BITS-1:0] r6;
    logic [PRG_BANK_BITS-1:0] r7;
    logic [7:0]               lo0;
    logic [7:0]               lo1;

    always_comb
    begin
        prg_rom_banks_next = prg_rom_banks_reg;
        chr_rom_kib_next   = chr_rom_kib_reg;
        four_screen_next   = four_screen_reg;
        cfg_hit            = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PRG_ROM_BANKS:
                begin
                    prg_rom_banks_next = cfg_data[6:0];
                    cfg_hit            = 1'b1;
                end
                CFG_CHR_ROM_KIB:
                begin
                    chr_rom_kib_next = cfg_data[8:0];
                    cfg_hit          = 1'b1;
                end
                CFG_FOUR_SCREEN:
                begin
                    four_screen_next = cfg_data[0];
                    cfg_hit          = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end

        prg_second8 = {1'b0, prg_rom_banks_next} - 8'd2;
        prg_last8   = {1'b0, prg_rom_banks_next} - 8'd1;
        prg_second  = prg_second8[PRG_BANK_BITS-1:0];
        prg_last    = prg_last8[PRG_BANK_BITS-1:0];
        chr_pair9   = chr_rom_kib_next - 9'd2;
        chr_last9   = chr_rom_kib_next - 9'd1;

        select_index_next = select_index_reg;
        prg_swap_next     = prg_swap_reg;
        chr_invert_next   = chr_invert_reg;
        if (cmd.sel_wr)
        begin
            select_index_next = cmd.data[2:0];
            prg_swap_next     = cmd.data[6];
            chr_invert_next   = cmd.data[7];
        end

        bank_values_next = bank_values_reg;
        if (cmd.bank_wr)
        begin
            bank_values_next[select_index_reg] = cmd.data;
        end

        lo0 = bank_values_next[0] & 8'hFE;
        lo1 = bank_values_next[1] & 8'hFE;
        r6  = bank_values_next[6][PRG_BANK_BITS-1:0];
        r7  = bank_values_next[7][PRG_BANK_BITS-1:0];

        prg_win_next = prg_win_reg;
        chr_win_next = chr_win_reg;
        loaded_next  = loaded_reg;

        if (cfg_hit && !loaded_reg)
        begin
            prg_win_next[0] = prg_second;
            prg_win_next[1] = prg_last;
            prg_win_next[2] = prg_second;
            prg_win_next[3] = prg_last;
            for (int i = 0; i < 8; i++)
            begin
                chr_win_next[i] = chr_last9[7:0];
            end
            chr_win_next[0] = chr_pair9[7:0];
            chr_win_next[3] = chr_pair9[7:0];
        end

        if (cmd.bank_wr)
        begin
            chr_win_next[{chr_invert_reg, 2'd0}] = lo0;
            chr_win_next[{chr_invert_reg, 2'd1}] = lo0 + 8'd1;
            chr_win_next[{chr_invert_reg, 2'd2}] = lo1;
            chr_win_next[{chr_invert_reg, 2'd3}] = lo1 + 8'd1;
            for (int i = 0; i < 4; i++)
            begin
                chr_win_next[{~chr_invert_reg, 2'(i)}] = bank_values_next[2 + i];
            end
            prg_win_next[0] = prg_swap_reg ? prg_second : r6;
            prg_win_next[1] = r7;
            prg_win_next[2] = prg_swap_reg ? r6 : prg_second;
            prg_win_next[3] = prg_last;
            loaded_next     = 1'b1;
        end

        mirror_next = mirroring_reg;
        if (cmd.mirror_wr)
        begin
            if (four_screen_reg)
            begin
                mirror_next = MIR_FOUR_SCREEN;
            end
            else
            begin
                mirror_next = cmd.data[0] ? MIR_HORIZONTAL : MIR_VERTICAL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_rom_banks_reg <= PRG_ROM_BANKS_RESET;
            chr_rom_kib_reg   <= CHR_ROM_KIB_RESET;
            four_screen_reg   <= 1'b0;
            select_index_reg  <= 3'd0;
            prg_swap_reg      <= 1'b0;
            chr_invert_reg    <= 1'b0;
            loaded_reg        <= 1'b0;
            mirroring_reg     <= MIR_HORIZONTAL;
            for (int i = 0; i < 8; i++)
            begin
                bank_values_reg[i] <= 8'd0;
                chr_win_reg[i]     <= CHR_DEF_LAST_RESET;
            end
            chr_win_reg[0] <= CHR_DEF_PAIR_RESET;
            chr_win_reg[3] <= CHR_DEF_PAIR_RESET;
            prg_win_reg[0] <= PRG_SECOND_RESET;
            prg_win_reg[1] <= PRG_LAST_RESET;
            prg_win_reg[2] <= PRG_SECOND_RESET;
            prg_win_reg[3] <= PRG_LAST_RESET;
        end
        else
        begin
            prg_rom_banks_reg <= prg_rom_banks_next;
            chr_rom_kib_reg   <= chr_rom_kib_next;
            four_screen_reg   <= four_screen_next;
            select_index_reg  <= select_index_next;
            prg_swap_reg      <= prg_swap_next;
            chr_invert_reg    <= chr_invert_next;
            loaded_reg        <= loaded_next;
            mirroring_reg     <= mirror_next;
            bank_values_reg   <= bank_values_next;
            prg_win_reg       <= prg_win_next;
            chr_win_reg       <= chr_win_next;
        end
    end

    assign prg_bank = prg_win_reg[prg_sel];
    assign chr_bank = chr_win_reg[chr_sel];

endmodule

### rtl/bsm_irq.sv
module bsm_irq
    import bsm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  bsm_irq_cmd_t cmd,
    output logic         irq_pulse
);

    logic [7:0] count_reg, count_next;
    logic [7:0] reload_value_reg, reload_value_next;
    logic       pending_reg, pending_next;
    logic       enabled_reg, enabled_next;
    logic [7:0] count_dec;

    always_comb
    begin
        count_next        = count_reg;
        reload_value_next = reload_value_reg;
        pending_next      = pending_reg;
        enabled_next      = enabled_reg;
        irq_pulse         = 1'b0;
        count_dec         = count_reg - 8'd1;

        if (cmd.latch_wr)
        begin
            reload_value_next = cmd.data;
        end
        if (cmd.reload_wr)
        begin
            count_next   = 8'd0;
            pending_next = 1'b1;
        end
        if (cmd.enable_wr)
        begin
            enabled_next = cmd.enable_val;
        end
        if (cmd.tick)
        begin
            if ((count_reg == 8'd0) || pending_reg)
            begin
                count_next   = reload_value_reg;
                pending_next = 1'b0;
            end
            else
            begin
                count_next = count_dec;
                irq_pulse  = (count_dec == 8'd0) && enabled_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= 8'd0;
            reload_value_reg <= 8'd0;
            pending_reg      <= 1'b0;
            enabled_reg      <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            reload_value_reg <= reload_value_next;
            pending_reg      <= pending_next;
            enabled_reg      <= enabled_next;
        end
    end

endmodule

### rtl/bank_switch_mapper_irq.sv
// An accepted input word passes through the input register, then the result register.
// Throughput: one word per cycle while out_stall is low; the input register and the result
// register each hold one word, so input accepts while a finished result waits to be taken.
// Reset (rst_n, asynchronous, active low) empties both registers, clears the bank and
// counter state and loads the default windows for 32 PRG and 128 CHR banks.
module bank_switch_mapper_irq
    import bsm_pkg::*;
#(
    parameter int PRG_BANK_BITS = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            opcode,
    input  logic [15:0]           bus_address,
    input  logic [7:0]            write_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            target,
    output logic [18:0]           mem_address,
    output logic                  mem_write,
    output logic                  irq_pulse,
    output logic [1:0]            mirror_mode,
    output logic                  mirror_changed
);

    localparam int PRG_FULL_W = PRG_BANK_BITS + 13 + 19;

    logic        in_valid_reg;
    logic [2:0]  op_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;
    logic        advance;

    logic        out_valid_reg;
    logic [2:0]  target_reg;
    logic [18:0] mem_address_reg;
    logic        mem_write_reg;
    logic        irq_pulse_reg;
    logic [1:0]  mirror_mode_reg;
    logic        mirror_changed_reg;

    bsm_bank_cmd_t            bank_cmd;
    bsm_irq_cmd_t             irq_cmd;
    logic [PRG_BANK_BITS-1:0] prg_bank;
    logic [7:0]               chr_bank;
    logic [1:0]               mirror_next;
    logic                     irq_now;
    logic [PRG_FULL_W-1:0]    prg_full;
    logic [18:0]              chr_full;

    logic [2:0]  target_next;
    logic [18:0] mem_address_next;
    logic        mem_write_next;
    logic        reg_wr;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    assign prg_full = {19'd0, prg_bank, addr_reg[12:0]};
    assign chr_full = {1'b0, chr_bank, addr_reg[9:0]};

    always_comb
    begin
        target_next      = TGT_NONE;
        mem_address_next = 19'd0;
        mem_write_next   = 1'b0;
        reg_wr           = 1'b0;
        unique case (op_reg)
            OP_CPU_READ, OP_CPU_WRITE:
            begin
                if (addr_reg[15:13] == 3'b011)
                begin
                    target_next      = TGT_PRG_RAM;
                    mem_address_next = {6'd0, addr_reg[12:0]};
                    mem_write_next   = (op_reg == OP_CPU_WRITE);
                end
                else if (addr_reg[15])
                begin
                    if (op_reg == OP_CPU_READ)
                    begin
                        target_next      = TGT_PRG_ROM;
                        mem_address_next = prg_full[18:0];
                    end
                    else
                    begin
                        reg_wr = 1'b1;
                    end
                end
            end
            OP_PPU_READ, OP_PPU_WRITE:
            begin
                if (addr_reg[15:13] == 3'b000)
                begin
                    if (op_reg == OP_PPU_READ)
                    begin
                        target_next      = TGT_CHR_ROM;
                        mem_address_next = chr_full;
                    end
                end
                else if (addr_reg[15:12] == 4'h2)
                begin
                    target_next      = TGT_NT_RAM;
                    mem_address_next = {7'd0, addr_reg[11:0]};
                    mem_write_next   = (op_reg == OP_PPU_WRITE);
                end
            end
            default:
            begin
                target_next = TGT_NONE;
            end
        endcase
    end

    always_comb
    begin
        bank_cmd.sel_wr    = advance && reg_wr && (addr_reg[14:13] == REG_SELECT) && !addr_reg[0];
        bank_cmd.bank_wr   = advance && reg_wr && (addr_reg[14:13] == REG_SELECT) && addr_reg[0];
        bank_cmd.mirror_wr = advance && reg_wr && (addr_reg[14:13] == REG_MIRROR) && !addr_reg[0];
        bank_cmd.data      = data_reg;

        irq_cmd.tick       = advance && (op_reg == OP_TICK);
        irq_cmd.latch_wr   = advance && reg_wr && (addr_reg[14:13] == REG_LATCH) && !addr_reg[0];
        irq_cmd.reload_wr  = advance && reg_wr && (addr_reg[14:13] == REG_LATCH) && addr_reg[0];
        irq_cmd.enable_wr  = advance && reg_wr && (addr_reg[14:13] == REG_ENABLE);
        irq_cmd.enable_val = addr_reg[0];
        irq_cmd.data       = data_reg;
    end

    bsm_bank #(
        .PRG_BANK_BITS (PRG_BANK_BITS)
    ) u_bank (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (bank_cmd),
        .prg_sel     (addr_reg[14:13]),
        .chr_sel     (addr_reg[12:10]),
        .prg_bank    (prg_bank),
        .chr_bank    (chr_bank),
        .mirror_next (mirror_next)
    );

    bsm_irq u_irq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (irq_cmd),
        .irq_pulse (irq_now)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg   <= opcode;
            addr_reg <= bus_address;
            data_reg <= write_data;
        end
        if (advance)
        begin
            target_reg         <= target_next;
            mem_address_reg    <= mem_address_next;
            mem_write_reg      <= mem_write_next;
            irq_pulse_reg      <= irq_now;
            mirror_mode_reg    <= mirror_next;
            mirror_changed_reg <= bank_cmd.mirror_wr;
        end
    end

    assign out_valid      = out_valid_reg;
    assign target         = target_reg;
    assign mem_address    = mem_address_reg;
    assign mem_write      = mem_write_reg;
    assign irq_pulse      = irq_pulse_reg;
    assign mirror_mode    = mirror_mode_reg;
    assign mirror_changed = mirror_changed_reg;

endmodule

### sim/bank_switch_mapper_irq_checker.sv
module bank_switch_mapper_irq_checker
    import bsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [2:0]            opcode,
    input  logic [15:0]           bus_address,
    input  logic [7:0]            write_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [2:0]            target,
    input  logic [18:0]           mem_address,
    input  logic                  mem_write,
    input  logic                  irq_pulse,
    input  logic [1:0]            mirror_mode,
    input  logic                  mirror_changed,
    output int                    result_errors,
    output int                    results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRG_BITS = 6;

    typedef struct packed {
        logic [2:0]  target;
        logic [18:0] mem_address;
        logic        mem_write;
        logic        irq_pulse;
        logic [1:0]  mirror_mode;
        logic        mirror_changed;
    } translation_t;

    translation_t expected_translations[$];

    logic [6:0]          prg_banks;
    logic [8:0]          chr_kib;
    logic                four_scr;
    logic [2:0]          sel_idx;
    logic                swap_mode;
    logic                chr_inv;
    logic [7:0]          bank_reg[8];
    logic [PRG_BITS-1:0] prg_window[4];
    logic [7:0]          chr_window[8];
    bit                  banks_loaded;
    logic [7:0]          irq_count;
    logic [7:0]          irq_latch;
    bit                  reload_pending;
    bit                  irq_on;
    logic [1:0]          mirroring;

    task automatic load_defaults();
        logic [PRG_BITS-1:0] second;
        logic [PRG_BITS-1:0] last;
        second = PRG_BITS'(prg_banks - 7'd2);
        last   = PRG_BITS'(prg_banks - 7'd1);
        prg_window[0] = second;
        prg_window[1] = last;
        prg_window[2] = second;
        prg_window[3] = last;
        for (int i = 0; i < 8; i++)
            chr_window[i] = 8'(chr_kib - 9'd1);
        chr_window[0] = 8'(chr_kib - 9'd2);
        chr_window[3] = 8'(chr_kib - 9'd2);
    endtask

    task automatic reset_mapper();
        prg_banks      = PRG_ROM_BANKS_RESET;
        chr_kib        = CHR_ROM_KIB_RESET;
        four_scr       = 1'b0;
        sel_idx        = '0;
        swap_mode      = 1'b0;
        chr_inv        = 1'b0;
        for (int i = 0; i < 8; i++)
            bank_reg[i] = '0;
        banks_loaded   = 1'b0;
        irq_count      = '0;
        irq_latch      = '0;
        reload_pending = 1'b0;
        irq_on         = 1'b0;
        mirroring      = MIR_HORIZONTAL;
        load_defaults();
    endtask

    task automatic recompute_windows();
        logic [7:0]          lo0;
        logic [7:0]          lo1;
        int                  half;
        int                  quad;
        logic [PRG_BITS-1:0] r6;
        logic [PRG_BITS-1:0] second;
        lo0    = bank_reg[0] & 8'hFE;
        lo1    = bank_reg[1] & 8'hFE;
        half   = chr_inv ? 4 : 0;
        quad   = chr_inv ? 0 : 4;
        r6     = bank_reg[6][PRG_BITS-1:0];
        second = PRG_BITS'(prg_banks - 7'd2);
        chr_window[half]     = lo0;
        chr_window[half + 1] = lo0 + 8'd1;
        chr_window[half + 2] = lo1;
        chr_window[half + 3] = lo1 + 8'd1;
        for (int i = 0; i < 4; i++)
            chr_window[quad + i] = bank_reg[2 + i];
        prg_window[0] = swap_mode ? second : r6;
        prg_window[1] = bank_reg[7][PRG_BITS-1:0];
        prg_window[2] = swap_mode ? r6 : second;
        prg_window[3] = PRG_BITS'(prg_banks - 7'd1);
        banks_loaded  = 1'b1;
    endtask

    task automatic write_mapper_reg(input logic [15:0] addr, input logic [7:0] data,
                                    output logic changed);
        changed = 1'b0;
        case (addr[14:13])
            REG_SELECT:
                if (!addr[0])
                begin
                    sel_idx   = data[2:0];
                    swap_mode = data[6];
                    chr_inv   = data[7];
                end
                else
                begin
                    bank_reg[sel_idx] = data;
                    recompute_windows();
                end
            REG_MIRROR:
                if (!addr[0])
                begin
                    if (four_scr)
                        mirroring = MIR_FOUR_SCREEN;
                    else
                        mirroring = data[0] ? MIR_HORIZONTAL : MIR_VERTICAL;
                    changed = 1'b1;
                end
            REG_LATCH:
                if (!addr[0])
                    irq_latch = data;
                else
                begin
                    irq_count      = '0;
                    reload_pending = 1'b1;
                end
            REG_ENABLE:
                irq_on = addr[0];
        endcase
    endtask

    task automatic translate_access(input logic [2:0] op, input logic [15:0] addr,
                                    input logic [7:0] data, output translation_t res);
        logic changed;
        res = '0;
        case (op)
            OP_CPU_READ, OP_CPU_WRITE:
                if (addr >= 16'h6000 && addr <= 16'h7FFF)
                begin
                    res.target      = TGT_PRG_RAM;
                    res.mem_address = {6'd0, addr[12:0]};
                    res.mem_write   = (op == OP_CPU_WRITE);
                end
                else if (addr[15])
                begin
                    if (op == OP_CPU_READ)
                    begin
                        res.target      = TGT_PRG_ROM;
                        res.mem_address = {prg_window[addr[14:13]], addr[12:0]};
                    end
                    else
                    begin
                        write_mapper_reg(addr, data, changed);
                        res.mirror_changed = changed;
                    end
                end
            OP_PPU_READ, OP_PPU_WRITE:
                if (addr < 16'h2000)
                begin
                    if (op == OP_PPU_READ)
                    begin
                        res.target      = TGT_CHR_ROM;
                        res.mem_address = {1'b0, chr_window[addr[12:10]], addr[9:0]};
                    end
                end
                else if (addr <= 16'h2FFF)
                begin
                    res.target      = TGT_NT_RAM;
                    res.mem_address = {7'd0, addr[11:0]};
                    res.mem_write   = (op == OP_PPU_WRITE);
                end
            OP_TICK:
                if (irq_count == 8'd0 || reload_pending)
                begin
                    irq_count      = irq_latch;
                    reload_pending = 1'b0;
                end
                else
                begin
                    irq_count = irq_count - 8'd1;
                    if (irq_count == 8'd0 && irq_on)
                        res.irq_pulse = 1'b1;
                end
            default: ;
        endcase
        res.mirror_mode = mirroring;
    endtask

    task automatic check_field(input string name, input logic [18:0] want,
                               input logic [18:0] got);
        if (got !== want)
        begin
            result_errors++;
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        translation_t want;
        if (!rst_n)
        begin
            reset_mapper();
            expected_translations.delete();
            results_owed = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_translations.size() == 0)
                begin
                    result_errors++;
                    $display("%0t ns: result word expected none, got target 0x%0h address 0x%0h",
                             $time, target, mem_address);
                end
                else
                begin
                    want = expected_translations.pop_front();
                    check_field("target", 19'(want.target), 19'(target));
                    check_field("mem_address", want.mem_address, mem_address);
                    check_field("mem_write", 19'(want.mem_write), 19'(mem_write));
                    check_field("irq_pulse", 19'(want.irq_pulse), 19'(irq_pulse));
                    check_field("mirror_mode", 19'(want.mirror_mode), 19'(mirror_mode));
                    check_field("mirror_changed", 19'(want.mirror_changed),
                                19'(mirror_changed));
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PRG_ROM_BANKS: prg_banks = cfg_data[6:0];
                    CFG_CHR_ROM_KIB:   chr_kib   = cfg_data[8:0];
                    CFG_FOUR_SCREEN:   four_scr  = cfg_data[0];
                    default: ;
                endcase
                if (!banks_loaded)
                    load_defaults();
            end
            if (in_valid && !in_stall)
            begin
                translate_access(opcode, bus_address, write_data, want);
                expected_translations.push_back(want);
            end
            results_owed = expected_translations.size();
        end
    end

endmodule

### sim/bank_switch_mapper_irq_test.sv
module bank_switch_mapper_irq_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bsm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 80;
    localparam int PHASES      = 5;
    localparam int PHASE_WORDS = 200;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_write      = 1'b0;
    logic [1:0]            cfg_index      = CFG_PRG_ROM_BANKS;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic [2:0]            opcode         = OP_CPU_READ;
    logic [15:0]           bus_address    = '0;
    logic [7:0]            write_data     = '0;
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic [2:0]            target;
    logic [18:0]           mem_address;
    logic                  mem_write;
    logic                  irq_pulse;
    logic [1:0]            mirror_mode;
    logic                  mirror_changed;
    int                    result_errors;
    int                    results_owed;

    bit idle_on       = 1'b1;
    bit long_hold_req = 1'b0;
    int cycle_count   = 0;

    bank_switch_mapper_irq uut (.*);

    bank_switch_mapper_irq_checker checker_inst (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : result_sink
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                if (long_hold_req)
                begin
                    long_hold_req = 1'b0;
                    hold = LONG_HOLD;
                end
                else if (idle_on && $urandom_range(0, 5) == 0)
                    hold = $urandom_range(1, 9);
            end
            out_stall <= (hold != 0);
            if (hold != 0)
                hold--;
        end
    end

    task automatic send_word(input logic [2:0] op, input logic [15:0] addr,
                             input logic [7:0] data);
        int gap;
        @(negedge clk);
        in_valid    <= 1'b1;
        opcode      <= op;
        bus_address <= addr;
        write_data  <= data;
        do
            @(posedge clk);
        while (in_stall);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic go_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic random_word();
        int         pick;
        logic [15:0] a;
        logic [7:0]  d;
        pick = $urandom_range(0, 99);
        a    = 16'($urandom_range(0, 65535));
        d    = 8'($urandom_range(0, 255));
        if (pick < 25)
            send_word(OP_CPU_READ, pick < 5 ? a : 16'($urandom_range(16'h6000, 16'hFFFF)), d);
        else if (pick < 35)
        begin
            // A bank select followed by the bank value it selects.
            send_word(OP_CPU_WRITE, {3'b100, a[12:1], 1'b0}, d);
            send_word(OP_CPU_WRITE, {3'b100, a[12:1], 1'b1}, 8'($urandom_range(0, 255)));
        end
        else if (pick < 50)
            send_word(OP_CPU_WRITE, pick < 40 ? a : 16'($urandom_range(16'h6000, 16'hFFFF)), d);
        else if (pick < 58)
            send_word(OP_CPU_WRITE, {2'b11, a[13:0]}, pick < 56 ? 8'($urandom_range(0, 4)) : d);
        else if (pick < 74)
            send_word(OP_PPU_READ, a[15] ? a : {2'b00, a[13:0]}, d);
        else if (pick < 82)
            send_word(OP_PPU_WRITE, a[15] ? a : {2'b00, a[13:0]}, d);
        else if (pick < 96)
            send_word(OP_TICK, a, d);
        else
            send_word(3'($urandom_range(5, 7)), a, d);
    endtask

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(OP_CPU_READ, 16'h8000, 8'h00);
        send_word(OP_CPU_READ, 16'hFFFF, 8'h00);
        send_word(OP_PPU_READ, 16'h0000, 8'h00);
        send_word(OP_PPU_READ, 16'h1FFF, 8'h00);

        // While no bank value has been written, size changes move the default windows.
        go_quiet();
        write_cfg(CFG_PRG_ROM_BANKS, 9'd4);
        write_cfg(CFG_CHR_ROM_KIB, 9'd8);
        write_cfg(CFG_FOUR_SCREEN, 9'd1);
        send_word(OP_CPU_READ, 16'hC000, 8'h00);
        send_word(OP_PPU_READ, 16'h0C00, 8'h00);
        send_word(OP_CPU_WRITE, 16'hA000, 8'h01);

        go_quiet();
        write_cfg(CFG_PRG_ROM_BANKS, 9'd64);
        write_cfg(CFG_CHR_ROM_KIB, 9'd256);
        write_cfg(CFG_FOUR_SCREEN, 9'd0);
        send_word(OP_CPU_READ, 16'hE000, 8'h00);
        send_word(OP_PPU_READ, 16'h0400, 8'h00);
        send_word(OP_CPU_READ, 16'h0000, 8'h00);
        send_word(OP_CPU_READ, 16'h6000, 8'h00);
        send_word(OP_CPU_WRITE, 16'h7FFF, 8'hFF);
        send_word(OP_PPU_WRITE, 16'h1000, 8'h55);
        send_word(OP_PPU_READ, 16'h2000, 8'h00);
        send_word(OP_PPU_WRITE, 16'h2FFF, 8'hAA);
        send_word(OP_PPU_READ, 16'h3000, 8'h00);
        send_word(3'd7, 16'hFFFF, 8'hFF);
        send_word(OP_CPU_WRITE, 16'h8000, 8'hC7);
        send_word(OP_CPU_READ, 16'h8000, 8'h00);
        send_word(OP_CPU_WRITE, 16'h8001, 8'hFF);
        send_word(OP_CPU_READ, 16'hA000, 8'h00);
        send_word(OP_CPU_WRITE, 16'hA001, 8'h00);
        send_word(OP_CPU_WRITE, 16'hA000, 8'h00);
        send_word(OP_CPU_WRITE, 16'hC000, 8'h01);
        send_word(OP_CPU_WRITE, 16'hC001, 8'h00);
        send_word(OP_CPU_WRITE, 16'hE001, 8'h00);
        send_word(OP_TICK, 16'h0000, 8'h00);
        send_word(OP_TICK, 16'hFFFF, 8'hFF);
        send_word(OP_TICK, 16'h0000, 8'h00);
        send_word(OP_CPU_WRITE, 16'hE000, 8'h00);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            go_quiet();
            if (ph == 0)
            begin
                write_cfg(CFG_PRG_ROM_BANKS, 9'd4);
                write_cfg(CFG_CHR_ROM_KIB, 9'd8);
                write_cfg(CFG_FOUR_SCREEN, 9'd1);
            end
            else if (ph == 1)
            begin
                write_cfg(CFG_PRG_ROM_BANKS, 9'd64);
                write_cfg(CFG_CHR_ROM_KIB, 9'd256);
                write_cfg(CFG_FOUR_SCREEN, 9'd0);
            end
            else
            begin
                write_cfg(CFG_PRG_ROM_BANKS, 9'($urandom_range(4, 64)));
                write_cfg(CFG_CHR_ROM_KIB, 9'($urandom_range(8, 256)));
                write_cfg(CFG_FOUR_SCREEN, 9'($urandom_range(0, 1)));
            end
            if (ph == PHASES - 1)
                idle_on = 1'b0;
            if (ph == 2)
                long_hold_req = 1'b1;
            for (int i = 0; i < PHASE_WORDS; i++)
                random_word();
        end

        go_quiet();
        repeat (10) @(negedge clk);
        if (result_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### bank_switch_mapper_irq.f
rtl/bsm_pkg.sv
rtl/bsm_bank.sv
rtl/bsm_irq.sv
rtl/bank_switch_mapper_irq.sv
sim/bank_switch_mapper_irq_checker.sv
sim/bank_switch_mapper_irq_test.sv
